// File: rtl/core/ski_pkg.sv
// Package for the servo keyframe interpolator.
// Holds operation and register codes, fixed field widths and reset poses.
// No dependencies.
package ski_pkg;

  // Field widths fixed by the item format.
  localparam int OP_W     = 2;
  localparam int ROW_W    = 9;
  localparam int CH_W     = 3;
  localparam int PULSE_W  = 12;
  localparam int STEPS_W  = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;
  localparam int MAX_CH   = 8;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STEPS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAST  = 1'd1;

  // Reset values of the registers.
  localparam logic [STEPS_W-1:0] STEPS_RESET = 16'd300;
  localparam logic [ROW_W-1:0]   LAST_RESET  = 9'd0;

  // Snap window: a channel closer than this distance to its target jumps there.
  localparam int SNAP_LIMIT = 5;

  // Magnitude width of count times span, and divider iteration count.
  localparam int MAG_W = 28;

  typedef logic [PULSE_W-1:0] pulse_t;

  localparam pulse_t PULSE_INIT [MAX_CH] = '{
    12'd1490, 12'd1455, 12'd1530, 12'd1480,
    12'd1950, 12'd1890, 12'd1910, 12'd830
  };

endpackage

// File: rtl/core/ski_in_if.sv
// Input channel of the servo keyframe interpolator.
// Depends on ski_pkg for field widths.
interface ski_in_if;
  logic                          valid;
  logic                          ready;
  logic [ski_pkg::OP_W-1:0]      operation;
  logic [ski_pkg::ROW_W-1:0]     row;
  logic [ski_pkg::CH_W-1:0]      channel;
  logic [ski_pkg::PULSE_W-1:0]   value;

  modport source (output valid, operation, row, channel, value, input ready);
  modport sink (input valid, operation, row, channel, value, output ready);
endinterface

// File: rtl/core/ski_out_if.sv
// Result channel of the servo keyframe interpolator.
// Depends on ski_pkg for field widths.
interface ski_out_if;
  logic                        valid;
  logic                        ready;
  logic [ski_pkg::PULSE_W-1:0] pulse_0;
  logic [ski_pkg::PULSE_W-1:0] pulse_1;
  logic [ski_pkg::PULSE_W-1:0] pulse_2;
  logic [ski_pkg::PULSE_W-1:0] pulse_3;
  logic [ski_pkg::PULSE_W-1:0] pulse_4;
  logic [ski_pkg::PULSE_W-1:0] pulse_5;
  logic [ski_pkg::PULSE_W-1:0] pulse_6;
  logic [ski_pkg::PULSE_W-1:0] pulse_7;
  logic [ski_pkg::ROW_W-1:0]   target_index;
  logic                        sequence_done;

  modport source (output valid, pulse_0, pulse_1, pulse_2, pulse_3, pulse_4, pulse_5,
                  pulse_6, pulse_7, target_index, sequence_done, input ready);
  modport sink (input valid, pulse_0, pulse_1, pulse_2, pulse_3, pulse_4, pulse_5,
                pulse_6, pulse_7, target_index, sequence_done, output ready);
endinterface

// File: rtl/core/ski_cfg_if.sv
// Configuration write channel of the servo keyframe interpolator.
// Depends on ski_pkg for index and data widths.
interface ski_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ski_pkg::CFG_IDX_W-1:0] index;
  logic [ski_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/ski_ram.sv
// Generic simple dual-port RAM with a registered read.
// No dependencies.
module ski_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/servo_keyframe_interpolator_unit.sv
// Top level of the servo keyframe interpolator.
// Depends on ski_pkg, ski_in_if, ski_out_if, ski_cfg_if and ski_ram.
//
// Usage: the input channel carries one beat per item: a pose write, a start,
// or a tick. Every accepted beat yields exactly one result beat with the
// eight pulse widths, the row being approached and a done flag. The
// configuration channel is always ready and writes steps_per_row (index 0)
// or last_row (index 1); write it only while the block is idle.
// Flow: a write, a start, or a tick while stopped goes from idle straight to the
// publish state and then into the output register. A tick while running reads two
// pose entries per channel, target row then previous row, and evaluates it; a
// channel that snaps or jumps takes its target value, and one that must interpolate
// runs a shift-subtract divider and a fix-up state. After the last channel the
// sequence step is settled and the result is published.
// One item is worked at a time; the next beat can be taken once the
// previous result sits in the output register, even if it is not yet taken.
// If the receiver stalls, the finished result waits in the block and no
// further beat is taken. Reset restores the power-on pulses and stops the
// sequence; the pose memory keeps no reset and must be written before use.
module servo_keyframe_interpolator_unit #(
  parameter int POSE_ROWS   = 512,
  parameter int SERVO_COUNT = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  ski_in_if.sink     in_bus,
  ski_out_if.source  out_bus,
  ski_cfg_if.sink    cfg_bus
);

  localparam int RW = $clog2(POSE_ROWS);
  localparam int AW = RW + ski_pkg::CH_W;
  localparam int PW = ski_pkg::PULSE_W;
  localparam int MW = ski_pkg::MAG_W;
  localparam logic [ski_pkg::CH_W-1:0] LAST_CH = ski_pkg::CH_W'(SERVO_COUNT - 1);
  localparam logic [12:0] ROW_LIMIT = 13'(POSE_ROWS);
  localparam logic [ski_pkg::ROW_W-1:0] ROW_TOP =
    (POSE_ROWS - 1 > 511) ? 9'd511 : 9'(POSE_ROWS - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TGT  = 4'd1;
  localparam logic [3:0] S_PRV  = 4'd2;
  localparam logic [3:0] S_EVAL = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_FIX  = 4'd5;
  localparam logic [3:0] S_END  = 4'd6;
  localparam logic [3:0] S_PUB  = 4'd7;

  logic [3:0]                   state_r;
  logic [ski_pkg::STEPS_W-1:0]  steps_r;
  logic [ski_pkg::ROW_W-1:0]    last_r;
  logic [ski_pkg::ROW_W-1:0]    prev_row_r;
  logic [ski_pkg::ROW_W-1:0]    tgt_row_r;
  logic                         have_prev_r;
  logic [ski_pkg::STEPS_W-1:0]  count_r;
  logic                         time_r;
  logic                         snap_r;
  logic                         run_r;
  logic [ski_pkg::CH_W-1:0]     ch_r;
  logic                         tick_snap_r;
  logic                         done_r;
  logic [PW-1:0]                tgt_val_r;
  logic [PW-1:0]                prev_val_r;
  logic                         neg_r;
  logic [MW-1:0]                quo_r;
  logic [ski_pkg::STEPS_W-1:0]  rem_r;
  logic [ski_pkg::STEPS_W-1:0]  div_r;
  logic [4:0]                   it_r;
  ski_pkg::pulse_t              pulse_r [ski_pkg::MAX_CH];
  ski_pkg::pulse_t              out_pulse_r [ski_pkg::MAX_CH];
  logic [ski_pkg::ROW_W-1:0]    out_tgt_r;
  logic                         out_done_r;
  logic                         out_valid_r;

  logic                         in_fire;
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [AW-1:0]                ram_raddr;
  logic [PW-1:0]                ram_rdata;
  logic [ski_pkg::STEPS_W-1:0]  count_nxt;
  logic signed [13:0]           diff;
  logic                         snap_hit;
  logic signed [13:0]           span;
  logic signed [30:0]           prod;
  logic [30:0]                  prod_mag;
  logic [16:0]                  rem_sh;
  logic                         rem_ge;
  logic [MW:0]                  q_mag;
  logic signed [MW+2:0]         q_val;
  logic signed [MW+2:0]         v_val;
  ski_pkg::pulse_t              v_clamp;
  logic [ski_pkg::ROW_W-1:0]    eff_last;
  logic                         all_snap;

  assign in_fire       = in_bus.valid && in_bus.ready;
  assign in_bus.ready  = (state_r == S_IDLE);
  assign cfg_bus.ready = 1'b1;

  // Pose writes that fall outside the table are dropped.
  assign ram_we = in_fire && (in_bus.operation == ski_pkg::OP_WRITE) &&
                  (13'(in_bus.row) < ROW_LIMIT) &&
                  (4'(in_bus.channel) < 4'(SERVO_COUNT));
  assign ram_waddr = {RW'(in_bus.row), in_bus.channel};
  assign ram_raddr = (state_r == S_TGT) ? {RW'(tgt_row_r), ch_r} : {RW'(prev_row_r), ch_r};

  ski_ram #(
    .WIDTH (PW),
    .DEPTH (POSE_ROWS * ski_pkg::MAX_CH)
  ) u_pose_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_bus.value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Saturating tick count.
  assign count_nxt = (count_r == 16'hFFFF) ? count_r : count_r + 16'd1;

  // Snap test against the target and the interpolation product.
  always_comb begin
    diff     = $signed({2'b00, pulse_r[ch_r]}) - $signed({2'b00, tgt_val_r});
    snap_hit = (diff < 14'sd5) && (diff > -14'sd5);
    span     = $signed({2'b00, tgt_val_r}) - $signed({2'b00, ram_rdata});
    prod     = $signed({1'b0, count_r}) * span;
    prod_mag = prod[30] ? 31'(-prod) : 31'(prod);
  end

  // One restoring divider step.
  always_comb begin
    rem_sh = {rem_r, quo_r[MW-1]};
    rem_ge = (rem_sh >= {1'b0, div_r});
  end

  // Round toward minus infinity, add to the previous pose and clamp.
  always_comb begin
    q_mag = {1'b0, quo_r} + (MW+1)'(neg_r && (rem_r != '0));
    q_val = neg_r ? -$signed({2'b00, q_mag}) : $signed({2'b00, q_mag});
    v_val = $signed((MW+3)'(prev_val_r)) + q_val;
    if (v_val < 0) begin
      v_clamp = '0;
    end else if (v_val > $signed((MW+3)'(4095))) begin
      v_clamp = 12'd4095;
    end else begin
      v_clamp = v_val[PW-1:0];
    end
  end

  always_comb begin
    eff_last = (last_r > ROW_TOP) ? ROW_TOP : last_r;
    all_snap = snap_r || tick_snap_r;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r <= ski_pkg::STEPS_RESET;
      last_r  <= ski_pkg::LAST_RESET;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        ski_pkg::REG_STEPS: steps_r <= cfg_bus.data;
        ski_pkg::REG_LAST:  last_r  <= cfg_bus.data[ski_pkg::ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Datapath registers of the channel being worked.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_PRV: begin
        tgt_val_r <= ram_rdata;
      end
      S_EVAL: begin
        prev_val_r <= ram_rdata;
        neg_r      <= prod[30];
        quo_r      <= prod_mag[MW-1:0];
        rem_r      <= '0;
        div_r      <= (steps_r == '0) ? 16'd1 : steps_r;
        it_r       <= '0;
      end
      S_DIV: begin
        quo_r <= {quo_r[MW-2:0], rem_ge};
        rem_r <= rem_ge ? 16'(rem_sh - {1'b0, div_r}) : rem_sh[15:0];
        it_r  <= it_r + 5'd1;
      end
      default: ;
    endcase
  end

  // Sequencer, pose state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_row_r  <= '0;
      tgt_row_r   <= '0;
      have_prev_r <= 1'b0;
      count_r     <= '0;
      time_r      <= 1'b0;
      snap_r      <= 1'b0;
      run_r       <= 1'b0;
      ch_r        <= '0;
      tick_snap_r <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < ski_pkg::MAX_CH; c++) begin
        pulse_r[c] <= (c < SERVO_COUNT) ? ski_pkg::PULSE_INIT[c] : '0;
      end
    end else begin
      // The result beat is raised when published and dropped when taken.
      if (state_r == S_PUB && (!out_valid_r || out_bus.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            done_r <= 1'b0;
            if (in_bus.operation == ski_pkg::OP_START) begin
              run_r       <= 1'b1;
              tgt_row_r   <= '0;
              prev_row_r  <= '0;
              have_prev_r <= 1'b0;
              count_r     <= '0;
              time_r      <= 1'b0;
              snap_r      <= 1'b0;
              state_r     <= S_PUB;
            end else if (in_bus.operation == ski_pkg::OP_TICK && run_r) begin
              count_r     <= count_nxt;
              time_r      <= time_r || (count_nxt >= steps_r);
              ch_r        <= '0;
              tick_snap_r <= 1'b1;
              state_r     <= S_TGT;
            end else begin
              state_r <= S_PUB;
            end
          end
        end
        S_TGT: begin
          state_r <= S_PRV;
        end
        S_PRV: begin
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          if (snap_hit || !have_prev_r) begin
            pulse_r[ch_r] <= tgt_val_r;
            if (!snap_hit) begin
              tick_snap_r <= 1'b0;
            end
            ch_r    <= ch_r + 3'd1;
            state_r <= (ch_r == LAST_CH) ? S_END : S_TGT;
          end else begin
            tick_snap_r <= 1'b0;
            state_r     <= S_DIV;
          end
        end
        S_DIV: begin
          if (it_r == 5'(MW - 1)) begin
            state_r <= S_FIX;
          end
        end
        S_FIX: begin
          pulse_r[ch_r] <= v_clamp;
          ch_r          <= ch_r + 3'd1;
          state_r       <= (ch_r == LAST_CH) ? S_END : S_TGT;
        end
        S_END: begin
          state_r <= S_PUB;
          if (time_r && all_snap) begin
            time_r  <= 1'b0;
            snap_r  <= 1'b0;
            count_r <= '0;
            if (tgt_row_r >= eff_last) begin
              run_r       <= 1'b0;
              tgt_row_r   <= '0;
              prev_row_r  <= '0;
              have_prev_r <= 1'b0;
              done_r      <= 1'b1;
            end else begin
              prev_row_r  <= tgt_row_r;
              tgt_row_r   <= tgt_row_r + 9'd1;
              have_prev_r <= 1'b1;
            end
          end else begin
            snap_r <= all_snap;
          end
        end
        S_PUB: begin
          if (!out_valid_r || out_bus.ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Result payload, captured when the beat is published.
  always_ff @(posedge clk) begin
    if (state_r == S_PUB && (!out_valid_r || out_bus.ready)) begin
      out_pulse_r <= pulse_r;
      out_tgt_r   <= tgt_row_r;
      out_done_r  <= done_r;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.pulse_0       = out_pulse_r[0];
  assign out_bus.pulse_1       = out_pulse_r[1];
  assign out_bus.pulse_2       = out_pulse_r[2];
  assign out_bus.pulse_3       = out_pulse_r[3];
  assign out_bus.pulse_4       = out_pulse_r[4];
  assign out_bus.pulse_5       = out_pulse_r[5];
  assign out_bus.pulse_6       = out_pulse_r[6];
  assign out_bus.pulse_7       = out_pulse_r[7];
  assign out_bus.target_index  = out_tgt_r;
  assign out_bus.sequence_done = out_done_r;

endmodule

// File: rtl/core/ski_checker.sv
// Port-level checks for the servo keyframe interpolator, and their binding.
// Depends on servo_keyframe_interpolator_unit and its channel interfaces.
module ski_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [8:0] out_target_index,
  input logic       out_sequence_done,
  input logic [11:0] out_pulse_0
);

  // A result beat waits, unchanged, until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pulse_0)
    && $stable(out_target_index))
    else $error("result beat changed while stalled");

  // The block works on one item at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  // A finished sequence rewinds to the first row.
  a_done_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sequence_done |-> out_target_index == 9'd0)
    else $error("sequence done without rewind");

  // No result is shown straight out of reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat after reset");

endmodule

bind servo_keyframe_interpolator_unit ski_checker u_ski_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_bus.valid),
  .in_ready          (in_bus.ready),
  .out_valid         (out_bus.valid),
  .out_ready         (out_bus.ready),
  .out_target_index  (out_bus.target_index),
  .out_sequence_done (out_bus.sequence_done),
  .out_pulse_0       (out_bus.pulse_0)
);

// File: sim/ski_tb_if.sv
// Note on the testbench interfaces for the servo keyframe interpolator.
// The channel interfaces come from the RTL files ski_in_if, ski_out_if and ski_cfg_if.
// This file holds a small record type used by the stimulus table; depends on ski_pkg.
package ski_tb_pkg;

  // Operation code that the block treats as a no-op.
  localparam logic [ski_pkg::OP_W-1:0] OP_NOP = 2'd3;

  // One stimulus row: the input beat, plus an optional typed-in expected pulse 0,
  // target and done flag.
  typedef struct packed {
    logic [ski_pkg::OP_W-1:0]    operation;
    logic [ski_pkg::ROW_W-1:0]   row;
    logic [ski_pkg::CH_W-1:0]    channel;
    logic [ski_pkg::PULSE_W-1:0] value;
    logic                        chk;
    logic [ski_pkg::PULSE_W-1:0] exp_pulse_0;
    logic [ski_pkg::ROW_W-1:0]   exp_target;
    logic                        exp_done;
  } pose_cmd_t;
endpackage

// File: sim/tb_servo_keyframe_interpolator_unit.sv
// Testbench for servo_keyframe_interpolator_unit: directed table, then random pose sequences.
// Every result beat is checked against an in-bench interpolation predictor.
// Depends on ski_pkg, ski_tb_pkg and the ski_in_if, ski_out_if, ski_cfg_if interfaces.
module tb_servo_keyframe_interpolator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS = 512;
  localparam int LIMIT = 4000000;

  typedef struct packed {
    logic [7:0][ski_pkg::PULSE_W-1:0] pulse;
    logic [ski_pkg::ROW_W-1:0]        target;
    logic                             done;
    logic                             chk;
    logic [ski_pkg::PULSE_W-1:0]      exp_pulse_0;
    logic [ski_pkg::ROW_W-1:0]        exp_target;
    logic                             exp_done;
  } servo_frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #4 clk = ~clk;

  ski_in_if  in_bus ();
  ski_out_if out_bus ();
  ski_cfg_if cfg_bus ();

  servo_keyframe_interpolator_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus), .cfg_bus(cfg_bus)
  );

  // Predictor state.
  logic [ski_pkg::PULSE_W-1:0] pose_mem [ROWS*8];
  bit                          pose_known [ROWS*8];
  logic [ski_pkg::PULSE_W-1:0] pulse_q [8];
  logic [ski_pkg::ROW_W-1:0]   prev_row, tgt_row, last_row_q;
  logic [ski_pkg::STEPS_W-1:0] steps_q, ticks;
  bit has_prev, time_hit, snap_hit, seq_running;

  servo_frame_t frames_due [$];
  int  errors = 0;
  int  cycles = 0;
  int  send_idle = 0;
  int  recv_stall = 0;

  // Apply one beat to the predictor and queue the frame it must produce.
  function automatic void predict_frame(ski_tb_pkg::pose_cmd_t cmd);
    servo_frame_t f;
    int tv, pv, cur, nsnap, ends;
    longint num, d, q, v;
    bit done;
    done = 0;
    if (cmd.operation == ski_pkg::OP_WRITE) begin
      pose_mem[cmd.row*8 + cmd.channel] = cmd.value;
      pose_known[cmd.row*8 + cmd.channel] = 1;
    end else if (cmd.operation == ski_pkg::OP_START) begin
      seq_running = 1; tgt_row = 0; prev_row = 0; has_prev = 0;
      ticks = 0; time_hit = 0; snap_hit = 0;
    end else if (cmd.operation == ski_pkg::OP_TICK && seq_running) begin
      if (ticks != 16'hFFFF) ticks++;
      if (ticks >= steps_q) time_hit = 1;
      nsnap = 0;
      for (int c = 0; c < 8; c++) begin
        tv = pose_mem[tgt_row*8 + c];
        cur = pulse_q[c];
        if (cur - tv < ski_pkg::SNAP_LIMIT && cur - tv > -ski_pkg::SNAP_LIMIT) begin
          pulse_q[c] = pose_mem[tgt_row*8 + c]; nsnap++;
        end else if (has_prev) begin
          pv = pose_mem[prev_row*8 + c];
          num = longint'(ticks) * longint'(tv - pv);
          d = (steps_q == 0) ? 1 : steps_q;
          if (num >= 0) q = num / d;
          else q = -((-num + d - 1) / d);
          v = pv + q;
          if (v < 0) v = 0;
          if (v > 4095) v = 4095;
          pulse_q[c] = v[ski_pkg::PULSE_W-1:0];
        end else begin
          pulse_q[c] = pose_mem[tgt_row*8 + c];
        end
      end
      if (nsnap == 8) snap_hit = 1;
      if (time_hit && snap_hit) begin
        time_hit = 0; snap_hit = 0; ticks = 0;
        ends = last_row_q;
        if (tgt_row >= ends) begin
          seq_running = 0; tgt_row = 0; prev_row = 0; has_prev = 0; done = 1;
        end else begin
          prev_row = tgt_row; tgt_row = tgt_row + 9'd1; has_prev = 1;
        end
      end
    end
    for (int c = 0; c < 8; c++) f.pulse[c] = pulse_q[c];
    f.target = tgt_row;
    f.done = done;
    f.chk = cmd.chk;
    f.exp_pulse_0 = cmd.exp_pulse_0;
    f.exp_target = cmd.exp_target;
    f.exp_done = cmd.exp_done;
    frames_due.push_back(f);
  endfunction

  // Drive one input beat at the falling edge and hold it until accepted.
  task automatic send_cmd(ski_tb_pkg::pose_cmd_t cmd);
    @(negedge clk);
    while (send_idle > 0 && $urandom_range(99) < send_idle) @(negedge clk);
    in_bus.valid <= 1'b1;
    in_bus.operation <= cmd.operation;
    in_bus.row <= cmd.row;
    in_bus.channel <= cmd.channel;
    in_bus.value <= cmd.value;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    predict_frame(cmd);
    @(negedge clk);
    in_bus.valid <= 1'b0;
  endtask

  // Register write, only while idle.
  task automatic write_reg(logic [ski_pkg::CFG_IDX_W-1:0] idx,
                           logic [ski_pkg::CFG_DAT_W-1:0] dat);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= dat;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    if (idx == ski_pkg::REG_STEPS) steps_q = dat;
    else last_row_q = dat[ski_pkg::ROW_W-1:0];
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic drain();
    while (frames_due.size() > 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  // Receiver: random stall, check each accepted frame against the oldest expectation.
  always @(negedge clk) begin
    out_bus.ready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
  end

  always @(posedge clk) begin
    servo_frame_t got, want;
    cycles++;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got = '0;
      got.pulse = {out_bus.pulse_7, out_bus.pulse_6, out_bus.pulse_5, out_bus.pulse_4,
                   out_bus.pulse_3, out_bus.pulse_2, out_bus.pulse_1, out_bus.pulse_0};
      got.target = out_bus.target_index;
      got.done = out_bus.sequence_done;
      if (frames_due.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
      end else begin
        want = frames_due.pop_front();
        for (int c = 0; c < 8; c++)
          if (got.pulse[c] !== want.pulse[c]) begin
            $display("%0t: pulse_%0d expected %0d actual %0d", $time, c,
                     want.pulse[c], got.pulse[c]);
            errors++;
          end
        if (got.target !== want.target) begin
          $display("%0t: target_index expected %0d actual %0d", $time, want.target, got.target);
          errors++;
        end
        if (got.done !== want.done) begin
          $display("%0t: sequence_done expected %0d actual %0d", $time, want.done, got.done);
          errors++;
        end
        // Rows of the directed table carry a typed-in result as well.
        if (want.chk && (got.pulse[0] !== want.exp_pulse_0 ||
                         got.target !== want.exp_target || got.done !== want.exp_done)) begin
          $display("%0t: pulse_0/target/done expected %0d/%0d/%0d actual %0d/%0d/%0d",
                   $time, want.exp_pulse_0, want.exp_target, want.exp_done,
                   got.pulse[0], got.target, got.done);
          errors++;
        end
      end
    end
  end

  function automatic ski_tb_pkg::pose_cmd_t mk(logic [ski_pkg::OP_W-1:0] op, int r, int ch,
                                               int val);
    ski_tb_pkg::pose_cmd_t c;
    c = '0;
    c.operation = op;
    c.row = r[ski_pkg::ROW_W-1:0];
    c.channel = ch[ski_pkg::CH_W-1:0];
    c.value = val[ski_pkg::PULSE_W-1:0];
    return c;
  endfunction

  // A stimulus row with its expected pulse 0, target and done flag typed in.
  function automatic ski_tb_pkg::pose_cmd_t mkx(logic [ski_pkg::OP_W-1:0] op, int r, int ch,
                                                int val, int p0, int tgt, bit dn);
    ski_tb_pkg::pose_cmd_t c;
    c = mk(op, r, ch, val);
    c.chk = 1'b1;
    c.exp_pulse_0 = p0[ski_pkg::PULSE_W-1:0];
    c.exp_target = tgt[ski_pkg::ROW_W-1:0];
    c.exp_done = dn;
    return c;
  endfunction

  // Load rows 0..n with random poses, mostly near one another, some extremes.
  task automatic load_rows(int n, bit wide);
    for (int r = 0; r <= n; r++)
      for (int ch = 0; ch < 8; ch++)
        send_cmd(mk(ski_pkg::OP_WRITE, r, ch,
                    wide ? $urandom_range(4095) : $urandom_range(900, 2100)));
  endtask

  // Run a sequence: start, then ticks until done or the budget runs out.
  task automatic run_sequence(int max_ticks);
    send_cmd(mk(ski_pkg::OP_START, $urandom_range(511), $urandom_range(7),
                $urandom_range(4095)));
    for (int t = 0; t < max_ticks && seq_running; t++)
      send_cmd(mk(ski_pkg::OP_TICK, $urandom_range(511), $urandom_range(7),
                  $urandom_range(4095)));
  endtask

  ski_tb_pkg::pose_cmd_t directed [] = '{
    mkx(ski_pkg::OP_TICK, 0, 0, 0, 1490, 0, 0),        // tick while idle: power-on pulses stay
    mkx(ski_tb_pkg::OP_NOP, 511, 7, 4095, 1490, 0, 0), // operation 3 is a no-op
    mk(ski_pkg::OP_WRITE, 0, 0, 0), mk(ski_pkg::OP_WRITE, 0, 1, 4095),
    mk(ski_pkg::OP_WRITE, 0, 2, 1530), mk(ski_pkg::OP_WRITE, 0, 3, 1483),
    mk(ski_pkg::OP_WRITE, 0, 4, 1950), mk(ski_pkg::OP_WRITE, 0, 5, 2048),
    mk(ski_pkg::OP_WRITE, 0, 6, 1), mk(ski_pkg::OP_WRITE, 0, 7, 830),
    mk(ski_pkg::OP_WRITE, 511, 7, 4095), mk(ski_pkg::OP_WRITE, 511, 0, 0),
    mkx(ski_pkg::OP_START, 0, 0, 0, 1490, 0, 0),
    mkx(ski_pkg::OP_TICK, 0, 0, 0, 0, 0, 0),           // first segment jumps to row 0
    mkx(ski_pkg::OP_TICK, 0, 0, 0, 0, 0, 1),           // all snapped on the last row: done
    mkx(ski_pkg::OP_TICK, 0, 0, 0, 0, 0, 0),           // idle again
    mkx(ski_pkg::OP_START, 0, 0, 0, 0, 0, 0),          // start again from row 0
    mkx(ski_pkg::OP_TICK, 0, 0, 0, 0, 0, 1)
  };

  initial begin
    in_bus.valid = 1'b0; in_bus.operation = ski_pkg::OP_WRITE; in_bus.row = '0;
    in_bus.channel = '0; in_bus.value = '0;
    cfg_bus.valid = 1'b0; cfg_bus.index = ski_pkg::REG_STEPS; cfg_bus.data = '0;
    out_bus.ready = 1'b1;
    for (int c = 0; c < 8; c++) pulse_q[c] = ski_pkg::PULSE_INIT[c];
    steps_q = ski_pkg::STEPS_RESET; last_row_q = ski_pkg::LAST_RESET;
    prev_row = 0; tgt_row = 0; ticks = 0;
    has_prev = 0; time_hit = 0; snap_hit = 0; seq_running = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table with steps_per_row at one, then a short run with it at zero.
    write_reg(ski_pkg::REG_STEPS, 16'd1);
    foreach (directed[i]) send_cmd(directed[i]);
    drain();
    write_reg(ski_pkg::REG_STEPS, 16'd0);   // zero steps acts as one
    run_sequence(4);
    drain();

    // Random phases: each idling mode, several register settings.
    for (int ph = 0; ph < 24; ph++) begin
      int nrows, steps;
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 63; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 63; end
        default: begin send_idle = 17; recv_stall = 17; end
      endcase
      nrows = (ph == 7 || ph == 11) ? 2 : $urandom_range(0, 2);
      steps = (ph == 5) ? 65535 : (ph == 9) ? 1 : $urandom_range(1, 12);
      write_reg(ski_pkg::REG_STEPS, 16'(steps));
      write_reg(ski_pkg::REG_LAST, (ph == 11) ? 16'd511 : 16'(nrows));
      load_rows(nrows, ph[0]);
      if (ph == 11) begin
        // Last row at the table end: a few ticks that stay within the loaded rows.
        run_sequence(3);
      end else begin
        run_sequence(steps > 20 ? 6 : 40);
        // A few broken sequences: writes, restarts and no-ops mixed with ticks.
        for (int k = 0; k < 16; k++) begin
          int sel;
          sel = $urandom_range(9);
          if (sel == 0) send_cmd(mk(ski_pkg::OP_START, 0, 0, 0));
          else if (sel == 1) send_cmd(mk(ski_pkg::OP_WRITE, $urandom_range(nrows),
                                         $urandom_range(7), $urandom_range(4095)));
          else if (sel == 2) send_cmd(mk(ski_tb_pkg::OP_NOP, $urandom_range(511),
                                         $urandom_range(7), $urandom_range(4095)));
          else if (seq_running || pose_known[0]) send_cmd(mk(ski_pkg::OP_TICK, 0, 0, 0));
        end
      end
      drain();
      write_reg(ski_pkg::REG_LAST, 16'd0);
    end

    drain();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

// File: filelist.f
rtl/core/ski_pkg.sv
rtl/core/ski_in_if.sv
rtl/core/ski_out_if.sv
rtl/core/ski_cfg_if.sv
rtl/core/ski_ram.sv
rtl/core/servo_keyframe_interpolator_unit.sv
rtl/core/ski_checker.sv
sim/ski_tb_if.sv
sim/tb_servo_keyframe_interpolator_unit.sv
